FILE: hw/rtl/gdd_pkg.sv
// Shared types and constants for the Gregorian date difference block.
`default_nettype none

package gdd_pkg;

    localparam int unsigned YEAR_W     = 14;
    localparam int unsigned MONTH_W    = 4;
    localparam int unsigned DAY_W      = 5;
    localparam int unsigned DAYNUM_W   = 24;
    localparam int unsigned COUNT_W    = 22;
    localparam int unsigned OFFSET_W   = 10;
    localparam int unsigned QPROD_W    = 27;
    localparam int unsigned QUOT_W     = 8;
    localparam int unsigned RECIP_100  = 5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef logic [YEAR_W-1:0]   year_t;
    typedef logic [MONTH_W-1:0]  month_t;
    typedef logic [DAY_W-1:0]    day_t;
    typedef logic [DAYNUM_W-1:0] daynum_t;

    typedef struct packed {
        year_t  year;
        month_t month;
        day_t   day;
    } date_t;

    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_DEC = 4'd12;

    localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

endpackage

`default_nettype wire

FILE: hw/rtl/gregorian_date_difference.sv
// Top level: inclusive day count between two Gregorian dates.
//
//  Channel | Ports                             | Item
//  --------+-----------------------------------+------------------------------
//  input   | s_tvalid, s_tready, s_tdata[47:0] | two dates (day, month, year)
//  result  | m_tvalid, m_tready, m_tdata[23:0] | inclusive day count
//
// One item is taken every cycle while the result is not stalled.
// Four stages per date (clamp, constant products, leap and partial sums,
// final sum) feed a shared stage for the difference.
// A stalled result freezes the whole pipeline; s_tready is low only then and in reset.
// Reset clears the valid bits; payload registers keep their contents.
`default_nettype none

module gregorian_date_difference #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // first_day[4:0], first_month[8:5], first_year[22:9],
    // second_day[27:23], second_month[31:28], second_year[45:32], zero pad
    input  wire logic [gdd_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // inclusive_day_count[21:0], zero pad
    output logic [gdd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    logic             en;
    logic [3:0]       vld_reg;
    logic             out_vld_reg;
    logic [gdd_pkg::COUNT_W-1:0] count_reg, count_next;
    gdd_pkg::date_t   first_date;
    gdd_pkg::date_t   second_date;
    gdd_pkg::daynum_t first_num;
    gdd_pkg::daynum_t second_num;
    gdd_pkg::daynum_t diff;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en && aresetn;

    assign first_date  = gdd_pkg::date_t'(s_tdata[22:0]);
    assign second_date = gdd_pkg::date_t'(s_tdata[45:23]);

    gdd_date_pipe #(.YEAR_LIMIT(YEAR_LIMIT)) u_first (
        .aclk       (aclk),
        .en         (en),
        .date_in    (first_date),
        .day_number (first_num)
    );

    gdd_date_pipe #(.YEAR_LIMIT(YEAR_LIMIT)) u_second (
        .aclk       (aclk),
        .en         (en),
        .date_in    (second_date),
        .day_number (second_num)
    );

    always_comb begin
        diff       = (first_num > second_num) ? first_num - second_num
                                              : second_num - first_num;
        count_next = gdd_pkg::COUNT_W'(diff + 24'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[2:0], s_tvalid};
            out_vld_reg <= vld_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            count_reg <= count_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, count_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/gdd_date_pipe.sv
// Four-stage pipeline that turns one date into its day number from 01/01/0001.
`default_nettype none

module gdd_date_pipe #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire gdd_pkg::date_t   date_in,
    output gdd_pkg::daynum_t      day_number
);

    localparam gdd_pkg::year_t LIMIT_Y =
        (YEAR_LIMIT > 16383) ? 14'(16383) : 14'(YEAR_LIMIT);

    // stage 1: clamp month and year fields
    gdd_pkg::day_t  s1_day_reg,   s1_day_next;
    logic [3:0]     s1_midx_reg,  s1_midx_next;
    gdd_pkg::year_t s1_year_reg,  s1_year_next;
    gdd_pkg::year_t s1_prior_reg, s1_prior_next;

    always_comb begin
        s1_day_next  = date_in.day;
        s1_year_next = (date_in.year > LIMIT_Y) ? LIMIT_Y : date_in.year;
        if (date_in.month <= gdd_pkg::MONTH_JAN) begin
            s1_midx_next = 4'd0;
        end else if (date_in.month > gdd_pkg::MONTH_DEC) begin
            s1_midx_next = gdd_pkg::MONTH_DEC - 4'd1;
        end else begin
            s1_midx_next = date_in.month - 4'd1;
        end
        s1_prior_next = (s1_year_next != '0) ? s1_year_next - 14'd1 : '0;
    end

    // stage 2: constant products
    gdd_pkg::day_t              s2_day_reg;
    logic [3:0]                 s2_midx_reg;
    gdd_pkg::year_t             s2_year_reg;
    gdd_pkg::year_t             s2_prior_reg;
    logic [22:0]                s2_p365_reg;
    logic [gdd_pkg::QPROD_W-1:0] s2_pq_reg;
    logic [gdd_pkg::QPROD_W-1:0] s2_yq_reg;

    // stage 3: leap flag and partial sums
    logic [gdd_pkg::QUOT_W-1:0]   q100;
    logic [gdd_pkg::QUOT_W-1:0]   yq100;
    logic [gdd_pkg::YEAR_W-1:0]   yq_times;
    logic                         rem0;
    logic                         leap;
    gdd_pkg::daynum_t             s3_partial_reg, s3_partial_next;
    logic [gdd_pkg::OFFSET_W-1:0] s3_offset_reg,  s3_offset_next;

    always_comb begin
        q100     = s2_pq_reg[gdd_pkg::QPROD_W-1:gdd_pkg::RECIP_SHIFT];
        yq100    = s2_yq_reg[gdd_pkg::QPROD_W-1:gdd_pkg::RECIP_SHIFT];
        yq_times = 14'(yq100) * 14'd100;
        rem0     = (s2_year_reg == yq_times);
        leap     = ((s2_year_reg[1:0] == 2'b00) && !rem0) || (rem0 && (yq100[1:0] == 2'b00));
        s3_partial_next = 24'(s2_p365_reg) + 24'(s2_prior_reg >> 2)
                        - 24'(q100) + 24'(q100 >> 2);
        s3_offset_next  = 10'(gdd_pkg::DAYS_BEFORE_MONTH[s2_midx_reg])
                        + 10'(leap && (s2_midx_reg >= 4'd2))
                        + 10'(s2_day_reg);
    end

    // stage 4: final sum
    gdd_pkg::daynum_t s4_total_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_day_reg   <= s1_day_next;
            s1_midx_reg  <= s1_midx_next;
            s1_year_reg  <= s1_year_next;
            s1_prior_reg <= s1_prior_next;

            s2_day_reg   <= s1_day_reg;
            s2_midx_reg  <= s1_midx_reg;
            s2_year_reg  <= s1_year_reg;
            s2_prior_reg <= s1_prior_reg;
            s2_p365_reg  <= 23'(s1_prior_reg) * 23'd365;
            s2_pq_reg    <= 27'(s1_prior_reg) * 27'(gdd_pkg::RECIP_100);
            s2_yq_reg    <= 27'(s1_year_reg) * 27'(gdd_pkg::RECIP_100);

            s3_partial_reg <= s3_partial_next;
            s3_offset_reg  <= s3_offset_next;

            s4_total_reg <= s3_partial_reg + 24'(s3_offset_reg);
        end
    end

    assign day_number = s4_total_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gdd_checker.sv
// Port-level checks for the date difference block, bound to the top level.
`default_nettype none

module gdd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow result stall");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:22] == 2'b00))
        else $error("result padding not zero");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
